### design/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion shorthands used by the top-level design file
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge outside reset
`define ADC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition must never be seen at a clock edge outside reset
`define ADC_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define ADC_ASSERT(lbl, clk, rst, prop, msg)
`define ADC_NEVER(lbl, clk, rst, cond, msg)

`endif

`endif

### design/adc_pkg.sv
// ---------------------------------------------------------------------------
// adc_pkg
// shared sizes, codes and types of the array delete compactor
// ---------------------------------------------------------------------------
package adc_pkg;

   localparam int DEPTH     = 64;
   localparam int ELEM_BITS = 32;
   localparam int IDX_W     = $clog2(DEPTH);
   localparam int CNT_W     = $clog2(DEPTH + 1);

   typedef logic [ELEM_BITS-1:0] elem_type;
   typedef logic [IDX_W-1:0]     idx_type;
   typedef logic [CNT_W-1:0]     cnt_type;

   typedef enum logic [2:0] {
      MODE_INIT      = 3'd0,
      MODE_APPEND    = 3'd1,
      MODE_DEL_POS   = 3'd2,
      MODE_DEL_FIRST = 3'd3,
      MODE_DEL_ALL   = 3'd4,
      MODE_READ      = 3'd5
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_BAD_POS  = 2'd1,
      ST_NO_MATCH = 2'd2,
      ST_FULL     = 2'd3
   } status_type;

   typedef enum logic {
      S_IDLE,
      S_SCAN
   } state_type;

   // control broadcast to every cell of the chain
   typedef struct packed {
      logic     shift;
      logic     wr;
      idx_type  wptr;
      elem_type wdata;
   } chain_ctrl_type;

endpackage

### design/adc_req_if.sv
// ---------------------------------------------------------------------------
// adc_req_if
// request channel: one operation per transaction
// ---------------------------------------------------------------------------
interface adc_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         mode;
   logic signed [31:0] value;
   logic [5:0]         position;
   logic [6:0]         start_capacity;

   modport source (output valid, output mode, output value, output position,
                   output start_capacity, input ready);
   modport sink   (input valid, input mode, input value, input position,
                   input start_capacity, output ready);
endinterface

### design/adc_rsp_if.sv
// ---------------------------------------------------------------------------
// adc_rsp_if
// response channel: one result per request transaction
// ---------------------------------------------------------------------------
interface adc_rsp_if;
   logic               valid;
   logic               ready;
   logic [6:0]         count_now;
   logic [6:0]         capacity_now;
   logic [6:0]         removed;
   logic signed [31:0] read_value;
   logic [1:0]         status;

   modport source (output valid, output count_now, output capacity_now,
                   output removed, output read_value, output status, input ready);
   modport sink   (input valid, input count_now, input capacity_now,
                   input removed, input read_value, input status, output ready);
endinterface

### design/adc_cell.sv
// ---------------------------------------------------------------------------
// adc_cell
// one storage cell of the element chain
// ---------------------------------------------------------------------------
module adc_cell import adc_pkg::*; (
   input  logic           clock,
   input  idx_type        cell_index,
   input  chain_ctrl_type ctrl,
   input  elem_type       upper,
   output elem_type       data
);

   elem_type elem_ff;
   elem_type elem_in;

   // a targeted write wins over the shift from the upper neighbor
   always_comb begin
      elem_in = elem_ff;
      if (ctrl.wr && (ctrl.wptr == cell_index)) begin
         elem_in = ctrl.wdata;
      end else if (ctrl.shift) begin
         elem_in = upper;
      end
   end

   always_ff @(posedge clock) begin
      elem_ff <= elem_in;
   end

   assign data = elem_ff;

endmodule

### design/adc_chain.sv
// ---------------------------------------------------------------------------
// adc_chain
// row of element cells, each shifting toward index zero
// ---------------------------------------------------------------------------
module adc_chain import adc_pkg::*; (
   input  logic           clock,
   input  chain_ctrl_type ctrl,
   output elem_type       head
);

   elem_type cell_data [DEPTH];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      elem_type upper;
      if (i == DEPTH - 1) begin : g_top
         assign upper = cell_data[i];
      end else begin : g_mid
         assign upper = cell_data[i+1];
      end

      adc_cell u_cell (
         .clock      (clock),
         .cell_index (IDX_W'(i)),
         .ctrl       (ctrl),
         .upper      (upper),
         .data       (cell_data[i])
      );
   end

   assign head = cell_data[0];

endmodule

### design/adc_ctrl.sv
// ---------------------------------------------------------------------------
// adc_ctrl
// operation sequencer, count and capacity tracking, response register
// ---------------------------------------------------------------------------
module adc_ctrl import adc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_mode,
   input  logic signed [31:0] req_value,
   input  logic [5:0]         req_position,
   input  logic [6:0]         req_start_capacity,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [6:0]         rsp_count_now,
   output logic [6:0]         rsp_capacity_now,
   output logic [6:0]         rsp_removed,
   output logic signed [31:0] rsp_read_value,
   output logic [1:0]         rsp_status,
   input  elem_type           head,
   output chain_ctrl_type     chain_ctrl,
   output logic               busy
);

   state_type  state_ff, state_in;
   cnt_type    cnt_ff, cnt_in;
   cnt_type    cap_ff, cap_in;
   mode_type   op_ff, op_in;
   elem_type   val_ff, val_in;
   logic [5:0] pos_ff, pos_in;
   cnt_type    rem_ff, rem_in;
   idx_type    idx_ff, idx_in;
   cnt_type    kept_ff, kept_in;
   cnt_type    removed_ff, removed_in;
   logic       found_ff, found_in;
   elem_type   rd_ff, rd_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [6:0]         rsp_count_ff, rsp_count_in;
   logic [6:0]         rsp_cap_ff, rsp_cap_in;
   logic [6:0]         rsp_removed_ff, rsp_removed_in;
   logic signed [31:0] rsp_read_ff, rsp_read_in;
   status_type         rsp_status_ff, rsp_status_in;

   mode_type   req_op;
   elem_type   req_elem;
   logic       req_fire;
   logic       pos_bad;
   logic       append_full;
   logic       start_scan;
   logic       last_step;
   logic       remove;
   logic       hit;
   logic       at_pos;
   cnt_type    wr_slot;
   cnt_type    cnt_dec;
   status_type imm_status;

   assign req_op      = mode_type'(req_mode);
   assign req_elem    = elem_type'(req_value);
   assign req_fire    = req_valid && req_ready;
   assign pos_bad     = 32'(req_position) >= 32'(cnt_ff);
   assign append_full = (cnt_ff >= cap_ff) || (32'(cnt_ff) >= DEPTH);
   assign last_step   = (state_ff == S_SCAN) && (rem_ff == CNT_W'(1));
   assign hit         = (head == val_ff);
   assign at_pos      = 32'(idx_ff) == 32'(pos_ff);
   assign wr_slot     = CNT_W'(rem_ff - 1'b1 + kept_ff);
   assign cnt_dec     = CNT_W'(cnt_ff - 1'b1);

   always_comb begin
      unique case (req_op)
         MODE_DEL_POS, MODE_READ:        start_scan = !pos_bad;
         MODE_DEL_FIRST, MODE_DEL_ALL:   start_scan = (cnt_ff != '0);
         default:                        start_scan = 1'b0;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire && start_scan) state_in = S_SCAN;
         end
         S_SCAN: begin
            if (last_step) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state outputs: handshake and chain control
   always_comb begin
      req_ready        = 1'b0;
      busy             = 1'b0;
      remove           = 1'b0;
      chain_ctrl.shift = 1'b0;
      chain_ctrl.wr    = 1'b0;
      chain_ctrl.wptr  = '0;
      chain_ctrl.wdata = '0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = !rsp_valid_ff || rsp_ready;
            if (req_fire && (req_op == MODE_APPEND) && !append_full) begin
               chain_ctrl.wr    = 1'b1;
               chain_ctrl.wptr  = cnt_ff[IDX_W-1:0];
               chain_ctrl.wdata = req_elem;
            end
         end
         S_SCAN: begin
            busy = 1'b1;
            unique case (op_ff)
               MODE_DEL_POS:   remove = at_pos;
               MODE_DEL_FIRST: remove = hit && !found_ff;
               MODE_DEL_ALL:   remove = hit;
               default:        remove = 1'b0;
            endcase
            // pop the head; a kept element goes back behind the kept ones
            chain_ctrl.shift = 1'b1;
            chain_ctrl.wr    = !remove;
            chain_ctrl.wptr  = wr_slot[IDX_W-1:0];
            chain_ctrl.wdata = head;
         end
         default: ;
      endcase
   end

   // datapath
   always_comb begin
      cnt_in         = cnt_ff;
      cap_in         = cap_ff;
      op_in          = op_ff;
      val_in         = val_ff;
      pos_in         = pos_ff;
      rem_in         = rem_ff;
      idx_in         = idx_ff;
      kept_in        = kept_ff;
      removed_in     = removed_ff;
      found_in       = found_ff;
      rd_in          = rd_ff;
      imm_status     = ST_OK;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_count_in   = rsp_count_ff;
      rsp_cap_in     = rsp_cap_ff;
      rsp_removed_in = rsp_removed_ff;
      rsp_read_in    = rsp_read_ff;
      rsp_status_in  = rsp_status_ff;

      if (req_fire) begin
         op_in      = req_op;
         val_in     = req_elem;
         pos_in     = req_position;
         rem_in     = cnt_ff;
         idx_in     = '0;
         kept_in    = '0;
         removed_in = '0;
         found_in   = 1'b0;
         rd_in      = '0;
         unique case (req_op)
            MODE_INIT: begin
               cap_in = (32'(req_start_capacity) > DEPTH) ? CNT_W'(DEPTH)
                                                          : CNT_W'(req_start_capacity);
               cnt_in = '0;
            end
            MODE_APPEND: begin
               if (append_full) imm_status = ST_FULL;
               else             cnt_in     = CNT_W'(cnt_ff + 1'b1);
            end
            MODE_DEL_POS, MODE_READ: begin
               if (pos_bad) imm_status = ST_BAD_POS;
            end
            MODE_DEL_FIRST, MODE_DEL_ALL: begin
               if (cnt_ff == '0) imm_status = ST_NO_MATCH;
            end
            default: ;
         endcase
         if (!start_scan) begin
            rsp_valid_in   = 1'b1;
            rsp_count_in   = 7'(cnt_in);
            rsp_cap_in     = 7'(cap_in);
            rsp_removed_in = '0;
            rsp_read_in    = '0;
            rsp_status_in  = imm_status;
         end
      end else if (state_ff == S_SCAN) begin
         rem_in = CNT_W'(rem_ff - 1'b1);
         idx_in = IDX_W'(idx_ff + 1'b1);
         if (remove) begin
            cnt_in     = cnt_dec;
            removed_in = CNT_W'(removed_ff + 1'b1);
            found_in   = 1'b1;
            // shrink after each single removal
            if (cnt_dec <= (cap_ff >> 2)) cap_in = cap_ff >> 1;
         end else begin
            kept_in = CNT_W'(kept_ff + 1'b1);
         end
         if ((op_ff == MODE_READ) && at_pos) rd_in = head;
         if (last_step) begin
            rsp_valid_in   = 1'b1;
            rsp_count_in   = 7'(cnt_in);
            rsp_cap_in     = 7'(cap_in);
            rsp_removed_in = 7'(removed_in);
            rsp_read_in    = 32'(signed'(rd_in));
            if (((op_ff == MODE_DEL_FIRST) || (op_ff == MODE_DEL_ALL)) &&
                (removed_in == '0)) begin
               rsp_status_in = ST_NO_MATCH;
            end else begin
               rsp_status_in = ST_OK;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         cap_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      val_ff         <= val_in;
      pos_ff         <= pos_in;
      rem_ff         <= rem_in;
      idx_ff         <= idx_in;
      kept_ff        <= kept_in;
      removed_ff     <= removed_in;
      found_ff       <= found_in;
      rd_ff          <= rd_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_cap_ff     <= rsp_cap_in;
      rsp_removed_ff <= rsp_removed_in;
      rsp_read_ff    <= rsp_read_in;
      rsp_status_ff  <= rsp_status_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_count_now    = rsp_count_ff;
   assign rsp_capacity_now = rsp_cap_ff;
   assign rsp_removed      = rsp_removed_ff;
   assign rsp_read_value   = rsp_read_ff;
   assign rsp_status       = rsp_status_ff;

endmodule

### design/array_delete_compactor.sv
// ---------------------------------------------------------------------------
// array_delete_compactor
// packed signed-word array with init, append, deletes, read and capacity shrink
// ---------------------------------------------------------------------------
// Every request transaction gives exactly one response transaction. Init,
// append, unknown modes and requests rejected up front (position out of
// range, empty array on a match delete, full on append) have their response
// registered in the cycle after they are accepted. Delete at a position,
// delete first match, delete all matches and read rotate the stored
// elements once through the cell chain: one element leaves the chain head
// per cycle and is either dropped or written back behind the elements
// already kept, and once every stored element has passed the head the
// response is registered. The head compare examines one element per cycle.
// A new request is taken once the chain is idle and the response register
// is empty or being emptied. After each single removal the capacity halves
// when the count has fallen to a quarter of it or below. No clearing pass
// after reset.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module array_delete_compactor import adc_pkg::*; (
   input logic    clock,
   input logic    reset,
   adc_req_if.sink   req_chan,
   adc_rsp_if.source rsp_chan
);

   // chain control from the sequencer and the element leaving the head
   chain_ctrl_type chain_ctrl;
   elem_type       head;
   // high while a rotation is in progress
   logic           busy;

   adc_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_chan.valid),
      .req_ready          (req_chan.ready),
      .req_mode           (req_chan.mode),
      .req_value          (req_chan.value),
      .req_position       (req_chan.position),
      .req_start_capacity (req_chan.start_capacity),
      .rsp_valid          (rsp_chan.valid),
      .rsp_ready          (rsp_chan.ready),
      .rsp_count_now      (rsp_chan.count_now),
      .rsp_capacity_now   (rsp_chan.capacity_now),
      .rsp_removed        (rsp_chan.removed),
      .rsp_read_value     (rsp_chan.read_value),
      .rsp_status         (rsp_chan.status),
      .head               (head),
      .chain_ctrl         (chain_ctrl),
      .busy               (busy)
   );

   // element storage: one cell per entry, shifting toward the head
   adc_chain u_chain (
      .clock (clock),
      .ctrl  (chain_ctrl),
      .head  (head)
   );

   // count never exceeds capacity, capacity never exceeds the depth
   `ADC_ASSERT(a_cnt_cap, clock, reset, rsp_chan.valid |-> ((rsp_chan.count_now <= rsp_chan.capacity_now) && (32'(rsp_chan.capacity_now) <= DEPTH)), "count above capacity")

   // no new request while the chain is rotating
   `ADC_NEVER(a_busy_ready, clock, reset, busy && req_chan.ready, "request taken during rotation")

   // the response register is empty throughout a rotation
   `ADC_NEVER(a_busy_rsp, clock, reset, busy && rsp_chan.valid, "response pending during rotation")

   // the end of a rotation always presents its response
   `ADC_ASSERT(a_done_rsp, clock, reset, ($fell(busy) && !$past(reset)) |-> rsp_chan.valid, "rotation ended without response")

   // a failed request never returns read data
   `ADC_ASSERT(a_err_read, clock, reset, (rsp_chan.valid && (rsp_chan.status != ST_OK)) |-> (rsp_chan.read_value == '0), "read data on failed request")

endmodule
